### hw/rtl/spa_pkg.sv
package spa_pkg;

   localparam int unsigned STEP_W = 5;
   localparam logic [STEP_W-1:0] SQRT_LAST = 5'd31;
   localparam logic [STEP_W-1:0] DIV_LAST = 5'd16;
   localparam logic [15:0] ONE_Q14 = 16'h4000;
   localparam logic [16:0] T_ONE = 17'd65536;

   typedef logic [3:0][15:0] quat_type;
   typedef logic [2:0][15:0] vec_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LOAD, OP_DOT, OP_DSUM, OP_LERP, OP_SQ, OP_LEN, OP_SQRT,
      OP_DIVI, OP_DIV, OP_NORM, OP_E1, OP_E2, OP_E3, OP_WRITE, OP_EMIT
   } op_type;

   // which transform pair the compose engine works on
   typedef enum logic [1:0] {
      PASS_PARENT, PASS_REST, PASS_OUT
   } pass_type;

   typedef struct packed {
      op_type   op;
      pass_type pass;
   } cmd_type;

   typedef struct packed {
      logic driven;
      logic has_parent;
      logic undo;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic        first_bone;
      logic        driven;
      logic [8:0]  parent_index;
      logic [63:0] rot_from;
      logic [63:0] rot_to;
      logic [47:0] pos_from;
      logic [47:0] pos_to;
      logic [16:0] blend_factor;
      logic [63:0] rest_rot;
      logic [47:0] rest_pos;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  bone_number;
      logic [63:0] pose_rot;
      logic [47:0] pose_pos;
   } rsp_payload_type;

   function automatic logic [15:0] sat16(input logic signed [63:0] x);
      logic [15:0] r;
      if (x > 64'sd32767) r = 16'h7fff;
      else if (x < -64'sd32768) r = 16'h8000;
      else r = x[15:0];
      return r;
   endfunction

endpackage

### hw/rtl/spa_if.sv
interface spa_req_if;
   logic              valid;
   logic              ready;
   logic              first_bone;
   logic              driven;
   logic signed [8:0] parent_index;
   logic [63:0]       rot_from;
   logic [63:0]       rot_to;
   logic [47:0]       pos_from;
   logic [47:0]       pos_to;
   logic [16:0]       blend_factor;
   logic [63:0]       rest_rot;
   logic [47:0]       rest_pos;

   modport source (output valid, first_bone, driven, parent_index, rot_from, rot_to,
                   pos_from, pos_to, blend_factor, rest_rot, rest_pos, input ready);
   modport sink (input valid, first_bone, driven, parent_index, rot_from, rot_to,
                 pos_from, pos_to, blend_factor, rest_rot, rest_pos, output ready);
endinterface

interface spa_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  bone_number;
   logic [63:0] pose_rot;
   logic [47:0] pose_pos;

   modport source (output valid, bone_number, pose_rot, pose_pos, input ready);
   modport sink (input valid, bone_number, pose_rot, pose_pos, output ready);
endinterface

interface spa_csr_if;
   logic valid;
   logic ready;
   logic undo_rest_pose;

   modport source (output valid, undo_rest_pose, input ready);
   modport sink (input valid, undo_rest_pose, output ready);
endinterface

### hw/rtl/spa_controller.sv
module spa_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  spa_pkg::stat_type  stat,
   output spa_pkg::cmd_type   cmd
);

   typedef enum logic [15:0] {
      ST_IDLE  = 16'b0000_0000_0000_0001,
      ST_PREP  = 16'b0000_0000_0000_0010,
      ST_DOT   = 16'b0000_0000_0000_0100,
      ST_DSUM  = 16'b0000_0000_0000_1000,
      ST_LERP  = 16'b0000_0000_0001_0000,
      ST_SQ    = 16'b0000_0000_0010_0000,
      ST_LEN   = 16'b0000_0000_0100_0000,
      ST_SQRT  = 16'b0000_0000_1000_0000,
      ST_DIVI  = 16'b0000_0001_0000_0000,
      ST_DIV   = 16'b0000_0010_0000_0000,
      ST_NORM  = 16'b0000_0100_0000_0000,
      ST_E1    = 16'b0000_1000_0000_0000,
      ST_E2    = 16'b0001_0000_0000_0000,
      ST_E3    = 16'b0010_0000_0000_0000,
      ST_WRITE = 16'b0100_0000_0000_0000,
      ST_OUT   = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [spa_pkg::STEP_W-1:0] step_ff, step_in;
   spa_pkg::pass_type pass_ff, pass_in;
   spa_pkg::op_type op;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      pass_in = pass_ff;
      op = spa_pkg::OP_IDLE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = spa_pkg::OP_LOAD;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            pass_in = spa_pkg::PASS_PARENT;
            if (stat.driven) state_in = ST_DOT;
            else if (stat.has_parent) state_in = ST_E1;
            else state_in = ST_WRITE;
         end
         ST_DOT: begin
            op = spa_pkg::OP_DOT;
            state_in = ST_DSUM;
         end
         ST_DSUM: begin
            op = spa_pkg::OP_DSUM;
            state_in = ST_LERP;
         end
         ST_LERP: begin
            op = spa_pkg::OP_LERP;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            op = spa_pkg::OP_SQ;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            op = spa_pkg::OP_LEN;
            step_in = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            op = spa_pkg::OP_SQRT;
            step_in = step_ff + 1'b1;
            if (step_ff == spa_pkg::SQRT_LAST) state_in = ST_DIVI;
         end
         ST_DIVI: begin
            op = spa_pkg::OP_DIVI;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            op = spa_pkg::OP_DIV;
            step_in = step_ff + 1'b1;
            if (step_ff == spa_pkg::DIV_LAST) state_in = ST_NORM;
         end
         ST_NORM: begin
            op = spa_pkg::OP_NORM;
            pass_in = spa_pkg::PASS_PARENT;
            state_in = stat.has_parent ? ST_E1 : ST_WRITE;
         end
         ST_E1: begin
            op = spa_pkg::OP_E1;
            state_in = ST_E2;
         end
         ST_E2: begin
            op = spa_pkg::OP_E2;
            state_in = ST_E3;
         end
         ST_E3: begin
            op = spa_pkg::OP_E3;
            unique case (pass_ff)
               spa_pkg::PASS_PARENT: state_in = ST_WRITE;
               spa_pkg::PASS_REST: begin
                  pass_in = spa_pkg::PASS_OUT;
                  state_in = ST_E1;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_WRITE: begin
            op = spa_pkg::OP_WRITE;
            if (stat.undo) begin
               pass_in = spa_pkg::PASS_REST;
               state_in = ST_E1;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               op = spa_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         pass_ff <= spa_pkg::PASS_PARENT;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         pass_ff <= pass_in;
      end
   end

   assign cmd.op = op;
   assign cmd.pass = pass_ff;

endmodule

### hw/rtl/spa_datapath.sv
module spa_datapath #(
   parameter int unsigned MAX_BONES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spa_pkg::cmd_type         cmd,
   output spa_pkg::stat_type        stat,
   input  spa_pkg::req_payload_type req_data,
   input  logic                     csr_write,
   input  logic                     csr_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output spa_pkg::rsp_payload_type rsp_data
);

   localparam int unsigned IDXW = $clog2(MAX_BONES);
   localparam int unsigned CMPW = (IDXW > 8) ? IDXW : 8;
   localparam int unsigned ENTRY_W = 112;

   // bone state
   logic [IDXW-1:0] cnt_ff, idx_ff, par_addr_ff, idx_in, cnt_in;
   logic par_ok_ff, driven_ff, undo_ff, par_ok_in;
   logic [16:0] t_ff, t_in;
   spa_pkg::quat_type ra_ff, rb_ff, rr_ff, l_rot_ff, g_rot_ff, o_rot_ff, qr_ff;
   spa_pkg::vec_type pa_ff, pb_ff, rp_ff, l_pos_ff, g_pos_ff, i_pos_ff, o_pos_ff;

   // blend
   logic signed [31:0] dp_ff [4];
   logic signed [31:0] dp_in [4];
   logic signed [34:0] lp_ff [3];
   logic signed [34:0] lp_in [3];
   logic dneg_ff, dneg_in;
   spa_pkg::vec_type lpos_in;
   logic signed [24:0] c_ff [4];
   logic signed [24:0] c_in [4];
   logic [46:0] sq_ff [4];
   logic [46:0] sq_in [4];
   logic [63:0] sqx_ff, sqr_ff, sqb_ff, sq_trial, len_in;
   logic sq_ge;
   logic [47:0] rem_ff [4];
   logic [47:0] rem_in [4];
   logic [47:0] rem_step [4];
   logic [16:0] q_ff [4];
   logic [16:0] q_step [4];
   logic [47:0] dv_ff;
   logic [3:0] cneg_ff, cneg_in;
   spa_pkg::quat_type norm_rot;

   // compose engine
   spa_pkg::quat_type irot, eo_rot, ei_rot, qr_in;
   spa_pkg::vec_type eo_pos, ei_pos, e_pos;
   logic signed [31:0] qp_ff [16];
   logic signed [31:0] qp_in [16];
   logic signed [33:0] tt_ff [3];
   logic signed [33:0] tt_in [3];
   logic signed [51:0] acc_ff [3];
   logic signed [51:0] acc_in [3];

   // global transform store
   logic [ENTRY_W-1:0] mem [MAX_BONES];
   logic [ENTRY_W-1:0] rd_ff, wdata;

   logic out_valid_ff;
   logic [7:0] out_bone_ff;
   logic [63:0] out_rot_ff;
   logic [47:0] out_pos_ff;

   always_comb begin
      idx_in = req_data.first_bone ? '0 : cnt_ff;
      cnt_in = (idx_in == IDXW'(MAX_BONES - 1)) ? '0 : idx_in + 1'b1;
      par_ok_in = !req_data.parent_index[8] &&
                  (CMPW'(req_data.parent_index[7:0]) < CMPW'(idx_in));
      t_in = (req_data.blend_factor > spa_pkg::T_ONE) ? spa_pkg::T_ONE
                                                      : req_data.blend_factor;
   end

   // conjugate of rest rotation, negation saturates
   always_comb begin
      irot[0] = rr_ff[0];
      for (int i = 1; i < 4; i++) begin
         irot[i] = (rr_ff[i] == 16'h8000) ? 16'h7fff : 16'(-$signed(rr_ff[i]));
      end
   end

   // blend arithmetic
   always_comb begin
      logic signed [17:0] ts;
      logic signed [33:0] dsum;
      logic signed [16:0] bs;
      logic signed [17:0] d;
      logic signed [35:0] m;
      logic signed [37:0] x;
      logic signed [49:0] sqf;
      logic signed [35:0] lr;
      logic [23:0] mag;
      logic [16:0] qm;
      logic signed [17:0] sv;
      ts = $signed({1'b0, t_ff});
      dsum = '0;
      len_in = '0;
      for (int i = 0; i < 4; i++) begin
         dp_in[i] = $signed(ra_ff[i]) * $signed(rb_ff[i]);
         dsum = dsum + 34'(dp_ff[i]);
      end
      dneg_in = dsum[33];
      for (int i = 0; i < 3; i++) begin
         lp_in[i] = (17'($signed(pb_ff[i])) - 17'($signed(pa_ff[i]))) * ts;
         lr = (36'(lp_ff[i]) + 36'sd32768) >>> 16;
         lpos_in[i] = spa_pkg::sat16(64'($signed(pa_ff[i])) + 64'(lr));
      end
      for (int i = 0; i < 4; i++) begin
         bs = dneg_ff ? -17'($signed(rb_ff[i])) : 17'($signed(rb_ff[i]));
         d = 18'(bs) - 18'($signed(ra_ff[i]));
         m = d * ts;
         x = (38'($signed(ra_ff[i])) <<< 16) + 38'(m) + 38'sd128;
         c_in[i] = 25'(x >>> 8);
         sqf = c_ff[i] * c_ff[i];
         sq_in[i] = sqf[46:0];
         len_in = len_in + 64'(sq_ff[i]);
         mag = c_ff[i][24] ? 24'(-c_ff[i]) : 24'(c_ff[i]);
         cneg_in[i] = c_ff[i][24];
         rem_in[i] = (48'(mag) << 21) + 48'(sqr_ff[31:1]);
         if (rem_ff[i] >= dv_ff) begin
            rem_step[i] = rem_ff[i] - dv_ff;
            q_step[i] = {q_ff[i][15:0], 1'b1};
         end else begin
            rem_step[i] = rem_ff[i];
            q_step[i] = {q_ff[i][15:0], 1'b0};
         end
         qm = (q_ff[i] > 17'd65536) ? 17'd65536 : q_ff[i];
         sv = cneg_ff[i] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
         norm_rot[i] = spa_pkg::sat16(64'(sv));
      end
      // zero-length blend gives identity
      if (sqr_ff == '0) begin
         norm_rot = '0;
         norm_rot[0] = spa_pkg::ONE_Q14;
      end
      sq_trial = sqr_ff + sqb_ff;
      sq_ge = sqx_ff >= sq_trial;
   end

   // operand select for the compose engine
   always_comb begin
      unique case (cmd.pass)
         spa_pkg::PASS_REST: begin
            eo_rot = irot;
            eo_pos = '0;
            ei_rot = irot;
            ei_pos = rp_ff;
         end
         spa_pkg::PASS_OUT: begin
            eo_rot = g_rot_ff;
            eo_pos = g_pos_ff;
            ei_rot = irot;
            ei_pos = i_pos_ff;
         end
         default: begin
            eo_rot = rd_ff[63:0];
            eo_pos = rd_ff[111:64];
            ei_rot = l_rot_ff;
            ei_pos = l_pos_ff;
         end
      endcase
   end

   // compose: quaternion product and rotation v + w*t + u x t, t = 2 (u x v)
   always_comb begin
      logic signed [31:0] pa, pb;
      logic signed [32:0] df;
      logic signed [49:0] mw, ma, mb;
      logic signed [33:0] qs [4];
      logic signed [25:0] rv;
      logic signed [26:0] pv;
      int a, b;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            qp_in[4*i+j] = $signed(eo_rot[i]) * $signed(ei_rot[j]);
         end
      end
      qs[0] = 34'(qp_ff[0]) - 34'(qp_ff[5]) - 34'(qp_ff[10]) - 34'(qp_ff[15]);
      qs[1] = 34'(qp_ff[1]) + 34'(qp_ff[4]) + 34'(qp_ff[11]) - 34'(qp_ff[14]);
      qs[2] = 34'(qp_ff[2]) - 34'(qp_ff[7]) + 34'(qp_ff[8]) + 34'(qp_ff[13]);
      qs[3] = 34'(qp_ff[3]) + 34'(qp_ff[6]) - 34'(qp_ff[9]) + 34'(qp_ff[12]);
      for (int k = 0; k < 4; k++) begin
         qr_in[k] = spa_pkg::sat16(64'((qs[k] + 34'sd8192) >>> 14));
      end
      for (int i = 0; i < 3; i++) begin
         a = (i == 2) ? 0 : i + 1;
         b = (i == 0) ? 2 : i - 1;
         pa = $signed(eo_rot[a+1]) * $signed(ei_pos[b]);
         pb = $signed(eo_rot[b+1]) * $signed(ei_pos[a]);
         df = 33'(pa) - 33'(pb);
         tt_in[i] = {df, 1'b0};
         mw = $signed(eo_rot[0]) * tt_ff[i];
         ma = $signed(eo_rot[a+1]) * tt_ff[b];
         mb = $signed(eo_rot[b+1]) * tt_ff[a];
         acc_in[i] = 52'(mw) + 52'(ma) - 52'(mb);
         rv = 26'($signed(ei_pos[i])) + 26'((acc_ff[i] + 52'sd134217728) >>> 28);
         if (cmd.pass == spa_pkg::PASS_REST) pv = 27'($signed(eo_pos[i])) - 27'(rv);
         else pv = 27'($signed(eo_pos[i])) + 27'(rv);
         e_pos[i] = spa_pkg::sat16(64'(pv));
      end
   end

   assign wdata = par_ok_ff ? {g_pos_ff, g_rot_ff} : {l_pos_ff, l_rot_ff};

   always_ff @(posedge clock) begin
      if (cmd.op == spa_pkg::OP_WRITE) mem[idx_ff] <= wdata;
      rd_ff <= mem[par_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         undo_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) undo_ff <= csr_data;
         if (cmd.op == spa_pkg::OP_LOAD) cnt_ff <= cnt_in;
         if (cmd.op == spa_pkg::OP_EMIT) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         spa_pkg::OP_LOAD: begin
            idx_ff <= idx_in;
            par_addr_ff <= IDXW'(req_data.parent_index[7:0]);
            par_ok_ff <= par_ok_in;
            driven_ff <= req_data.driven;
            t_ff <= t_in;
            ra_ff <= req_data.rot_from;
            rb_ff <= req_data.rot_to;
            pa_ff <= req_data.pos_from;
            pb_ff <= req_data.pos_to;
            rr_ff <= req_data.rest_rot;
            rp_ff <= req_data.rest_pos;
            l_rot_ff <= req_data.rot_from;
            l_pos_ff <= req_data.pos_from;
         end
         spa_pkg::OP_DOT: begin
            dp_ff <= dp_in;
            lp_ff <= lp_in;
         end
         spa_pkg::OP_DSUM: begin
            dneg_ff <= dneg_in;
            l_pos_ff <= lpos_in;
         end
         spa_pkg::OP_LERP: c_ff <= c_in;
         spa_pkg::OP_SQ: sq_ff <= sq_in;
         spa_pkg::OP_LEN: begin
            sqx_ff <= len_in << 14;
            sqr_ff <= '0;
            sqb_ff <= 64'(1) << 62;
         end
         spa_pkg::OP_SQRT: begin
            if (sq_ge) begin
               sqx_ff <= sqx_ff - sq_trial;
               sqr_ff <= (sqr_ff >> 1) + sqb_ff;
            end else begin
               sqr_ff <= sqr_ff >> 1;
            end
            sqb_ff <= sqb_ff >> 2;
         end
         spa_pkg::OP_DIVI: begin
            rem_ff <= rem_in;
            cneg_ff <= cneg_in;
            dv_ff <= 48'(sqr_ff[31:0]) << 16;
            for (int i = 0; i < 4; i++) q_ff[i] <= '0;
         end
         spa_pkg::OP_DIV: begin
            rem_ff <= rem_step;
            q_ff <= q_step;
            dv_ff <= dv_ff >> 1;
         end
         spa_pkg::OP_NORM: l_rot_ff <= norm_rot;
         spa_pkg::OP_E1: begin
            qp_ff <= qp_in;
            tt_ff <= tt_in;
         end
         spa_pkg::OP_E2: begin
            qr_ff <= qr_in;
            acc_ff <= acc_in;
         end
         spa_pkg::OP_E3: begin
            unique case (cmd.pass)
               spa_pkg::PASS_REST: i_pos_ff <= e_pos;
               spa_pkg::PASS_OUT: begin
                  o_rot_ff <= qr_ff;
                  o_pos_ff <= e_pos;
               end
               default: begin
                  g_rot_ff <= qr_ff;
                  g_pos_ff <= e_pos;
               end
            endcase
         end
         spa_pkg::OP_WRITE: begin
            if (!par_ok_ff) begin
               g_rot_ff <= l_rot_ff;
               g_pos_ff <= l_pos_ff;
            end
         end
         spa_pkg::OP_EMIT: begin
            out_bone_ff <= 8'(idx_ff);
            out_rot_ff <= undo_ff ? o_rot_ff : g_rot_ff;
            out_pos_ff <= undo_ff ? o_pos_ff : g_pos_ff;
         end
         default: begin
         end
      endcase
   end

   assign stat.driven = driven_ff;
   assign stat.has_parent = par_ok_ff;
   assign stat.undo = undo_ff;
   assign stat.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_data.bone_number = out_bone_ff;
   assign rsp_data.pose_rot = out_rot_ff;
   assign rsp_data.pose_pos = out_pos_ff;

endmodule

### hw/rtl/skeletal_pose_accumulator.sv
// Skeletal pose accumulator: one bone per req beat, parents before children.
// req carries the bone's keyframes or local transform, its parent index and
// its rest transform; rsp returns one beat per bone with the bone number and
// the global pose (or the pose relative to rest when undo_rest_pose is set).
// csr writes undo_rest_pose; write it only while no bone is in flight.
// Steps per bone, accept to rsp valid: an undriven root bone passes prepare,
// write and output; a parent compose adds the compose steps E1 to E3, undo
// mode adds a rest pass and an output pass through them, and a driven bone
// adds four blend stages, length, a 32-step square root, divide setup, a
// 17-step divide over four lanes and the normalize. One bone is processed
// at a time; req is ready again the cycle after the result is loaded into
// the output register.
// Global transforms live in a MAX_BONES deep memory, read into a register
// that feeds the compose engine; an entry is only used after this pose has written it.
// Reset clears the bone counter, undo_rest_pose and the output valid; the
// memory is not cleared. When rsp stalls the result holds in the output
// register and the block stops before loading the next result.
module skeletal_pose_accumulator #(
   parameter int unsigned MAX_BONES = 256
) (
   input  logic      clock,
   input  logic      reset,
   spa_req_if.sink   req,
   spa_rsp_if.source rsp,
   spa_csr_if.sink   csr
);

   spa_pkg::cmd_type cmd;
   spa_pkg::stat_type stat;
   spa_pkg::req_payload_type req_data;
   spa_pkg::rsp_payload_type rsp_data;
   logic in_ready;

   assign req_data.first_bone = req.first_bone;
   assign req_data.driven = req.driven;
   assign req_data.parent_index = req.parent_index;
   assign req_data.rot_from = req.rot_from;
   assign req_data.rot_to = req.rot_to;
   assign req_data.pos_from = req.pos_from;
   assign req_data.pos_to = req.pos_to;
   assign req_data.blend_factor = req.blend_factor;
   assign req_data.rest_rot = req.rest_rot;
   assign req_data.rest_pos = req.rest_pos;

   assign req.ready = in_ready;
   assign csr.ready = 1'b1;

   spa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (in_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spa_datapath #(
      .MAX_BONES (MAX_BONES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_write (csr.valid),
      .csr_data  (csr.undo_rest_pose),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp.bone_number = rsp_data.bone_number;
   assign rsp.pose_rot = rsp_data.pose_rot;
   assign rsp.pose_pos = rsp_data.pose_pos;

endmodule
